// ----- hw/rtl/swmf_pkg.sv -----
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared widths, types and controller states of the sliding window median
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swmf_pkg;

  localparam int WINDOW = 8;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int TEMP_W = 11;
  localparam int HUM_W  = 10;
  localparam int SIW_W  = 4;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 32;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic        [HUM_W-1:0]  hum_t;
  typedef logic        [CNT_W-1:0]  count_t;
  typedef logic        [IDX_W-1:0]  idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic init;
    logic scan;
    logic decide;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// swmf_ctrl
// Sequencer of the rank-count sweep: accepts a beat, steps the scan over the
// window for each candidate entry, and hands the result to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire swmf_pkg::stat_t stat,
  output swmf_pkg::cmd_t      cmd
);
  import swmf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.j_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = stat.done ? ST_FINISH : ST_SCAN;
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // No beat is taken while reset is held.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.init = in_valid && !rst;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ST_FINISH: begin
        cmd.load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/swmf_datapath.sv -----
// ----------------------------------------------------------------------------
// swmf_datapath
// Reading rings, rank counters for both channels and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire swmf_pkg::cmd_t  cmd,
  output swmf_pkg::stat_t      stat,
  input  wire swmf_pkg::temp_t temp_in,
  input  wire swmf_pkg::hum_t  hum_in,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output swmf_pkg::temp_t      temp_med_out,
  output swmf_pkg::hum_t       hum_med_out,
  output logic [swmf_pkg::SIW_W-1:0] count_out
);
  import swmf_pkg::*;

  temp_t  temp_ring [WINDOW];
  hum_t   hum_ring  [WINDOW];
  idx_t   write_slot;
  count_t fill_count;

  idx_t   i_idx;
  idx_t   j_idx;
  logic   acc_en;

  temp_t  t_cand;
  temp_t  t_other;
  hum_t   h_cand;
  hum_t   h_other;

  count_t t_below;
  count_t t_same;
  count_t h_below;
  count_t h_same;
  logic   t_found;
  logic   h_found;
  temp_t  t_med;
  hum_t   h_med;

  count_t              target;
  count_t              fc_m1;
  logic [CNT_W:0]      t_upper;
  logic [CNT_W:0]      h_upper;
  logic                t_hit;
  logic                h_hit;

  // Ring storage; the new reading is written on the accepting edge.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      temp_ring[write_slot] <= temp_in;
      hum_ring[write_slot]  <= hum_in;
    end
    t_cand  <= temp_ring[i_idx];
    t_other <= temp_ring[j_idx];
    h_cand  <= hum_ring[i_idx];
    h_other <= hum_ring[j_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (cmd.init) begin
      write_slot <= (write_slot == IDX_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
      if (fill_count != CNT_W'(WINDOW)) fill_count <= fill_count + 1'b1;
    end
  end

  // Scan addresses: i picks the candidate, j walks the filled entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      i_idx  <= '0;
      j_idx  <= '0;
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.scan;
      if (cmd.init) begin
        i_idx <= '0;
        j_idx <= '0;
      end else if (cmd.decide) begin
        i_idx <= i_idx + 1'b1;
        j_idx <= '0;
      end else if (cmd.scan) begin
        j_idx <= j_idx + 1'b1;
      end
    end
  end

  assign target  = fill_count >> 1;
  assign fc_m1   = fill_count - 1'b1;
  assign t_upper = {1'b0, t_below} + {1'b0, t_same};
  assign h_upper = {1'b0, h_below} + {1'b0, h_same};
  assign t_hit   = (t_below <= target) && ({1'b0, target} < t_upper);
  assign h_hit   = (h_below <= target) && ({1'b0, target} < h_upper);

  // Read data arrives in the cycle after its address, so counting follows acc_en.
  always_ff @(posedge clk) begin
    if (cmd.init || cmd.decide) begin
      t_below <= '0;
      t_same  <= '0;
      h_below <= '0;
      h_same  <= '0;
    end else if (acc_en) begin
      if (t_other < t_cand) t_below <= t_below + 1'b1;
      else if (t_other == t_cand) t_same <= t_same + 1'b1;
      if (h_other < h_cand) h_below <= h_below + 1'b1;
      else if (h_other == h_cand) h_same <= h_same + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_found <= 1'b0;
      h_found <= 1'b0;
    end else if (cmd.init) begin
      t_found <= 1'b0;
      h_found <= 1'b0;
    end else if (cmd.decide) begin
      if (t_hit) t_found <= 1'b1;
      if (h_hit) h_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && t_hit && !t_found) t_med <= t_cand;
    if (cmd.decide && h_hit && !h_found) h_med <= h_cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp_med_out <= t_med;
      hum_med_out  <= h_med;
      count_out    <= SIW_W'(fill_count);
    end
  end

  assign stat.j_last   = (CNT_W'(j_idx) == fc_m1);
  assign stat.done     = (t_found || t_hit) && (h_found || h_hit);
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_median_filter_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_filter_unit
// Running median of the last WINDOW temperature and humidity readings.
// ----------------------------------------------------------------------------
// One beat is worked at a time; the next is taken once the result sits in
// the output register. The rank-count scan over the ring sets the rate.
// Reset clears the fill count and write slot; ring contents need no clearing.
`default_nettype none

module sliding_window_median_filter_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [10:0] temperature_sample, [20:11] humidity_sample, [23:21] zero
  input  wire logic [swmf_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [10:0] temperature_median, [20:11] humidity_median,
  // [24:21] samples_in_window, [31:25] zero
  output logic [swmf_pkg::OUT_W-1:0]       m_axis_tdata
);
  import swmf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  temp_t temp_med;
  hum_t  hum_med;
  logic [SIW_W-1:0] count;

  swmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swmf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .temp_in      (s_axis_tdata[TEMP_W-1:0]),
    .hum_in       (s_axis_tdata[TEMP_W+HUM_W-1:TEMP_W]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .temp_med_out (temp_med),
    .hum_med_out  (hum_med),
    .count_out    (count)
  );

  assign m_axis_tdata = {{(OUT_W - TEMP_W - HUM_W - SIW_W){1'b0}}, count, hum_med, temp_med};

endmodule

`default_nettype wire

// ----- verif/sliding_window_median_filter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_filter_unit_tb
// Drives paired temperature and humidity readings into the running median
// filter and checks every result beat against a behavioral window kept here.
// A short directed run covers field extremes, window growth, ties and a full
// descending window; random blocks of in-range, full-field and clustered
// readings follow. Sender and receiver stall at random in two of three phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_median_filter_unit_tb;
  import swmf_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PAD_LSB      = TEMP_W + HUM_W + SIW_W;
  localparam int MAX_PRINTS   = 20;

  typedef struct {
    temp_t t;
    hum_t  h;
  } reading_t;

  typedef struct {
    temp_t             t;
    hum_t              h;
    logic [SIW_W-1:0]  n;
  } median_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  reading_t       pending_readings[$];
  median_result_t expected_medians[$];
  int             total_readings = 0;
  int             loaded_readings = 0;
  int             accepted_readings = 0;
  int             mismatches = 0;
  int             cycles = 0;

  // Window state as the block should hold it.
  temp_t temp_ring[WINDOW];
  hum_t  hum_ring[WINDOW];
  int    write_slot = 0;
  int    fill_count = 0;

  sliding_window_median_filter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic queue_reading(input int t, input int h);
    reading_t r;
    r.t = temp_t'(t);
    r.h = hum_t'(h);
    pending_readings.push_back(r);
  endtask

  // Value at ascending rank n/2 among the first n entries; ties are settled
  // by counting how many entries fall below and how many are equal.
  function automatic int rank_median(input int vals[WINDOW], input int n);
    int below;
    int same;
    for (int i = 0; i < n; i++) begin
      below = 0;
      same  = 0;
      for (int j = 0; j < n; j++) begin
        if (vals[j] < vals[i]) begin
          below++;
        end else if (vals[j] == vals[i]) begin
          same++;
        end
      end
      if (below <= n / 2 && n / 2 < below + same) begin
        return vals[i];
      end
    end
    return 0;
  endfunction

  function automatic median_result_t slide_window(input temp_t t, input hum_t h);
    median_result_t res;
    int             temps[WINDOW];
    int             hums[WINDOW];
    temp_ring[write_slot] = t;
    hum_ring[write_slot]  = h;
    write_slot = (write_slot + 1) % WINDOW;
    if (fill_count < WINDOW) begin
      fill_count++;
    end
    for (int i = 0; i < WINDOW; i++) begin
      temps[i] = (i < fill_count) ? int'(temp_ring[i]) : 0;
      hums[i]  = (i < fill_count) ? int'(hum_ring[i]) : 0;
    end
    res.t = temp_t'(rank_median(temps, fill_count));
    res.h = hum_t'(rank_median(hums, fill_count));
    res.n = SIW_W'(fill_count);
    return res;
  endfunction

  // Driver: feeds readings from the pending queue and toggles the result
  // side ready, with stall rates that change over three phases.
  always @(posedge clk) begin
    int       send_idle;
    int       recv_idle;
    reading_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (loaded_readings < total_readings / 3) begin
        send_idle = 30;
        recv_idle = 75;
      end else if (loaded_readings < 2 * total_readings / 3) begin
        send_idle = 75;
        recv_idle = 30;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_readings.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          r = pending_readings.pop_front();
          s_axis_tdata  <= {{(IN_W - TEMP_W - HUM_W){1'b0}}, r.h, r.t};
          s_axis_tvalid <= 1'b1;
          loaded_readings++;
        end else begin
          s_axis_tdata  <= IN_W'($urandom);
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: the result side is checked before the new input beat is
  // folded into the window, so both share one process and one queue.
  always @(posedge clk) begin
    median_result_t want;
    temp_t          got_t;
    hum_t           got_h;
    logic [SIW_W-1:0] got_n;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_t = m_axis_tdata[TEMP_W-1:0];
        got_h = m_axis_tdata[TEMP_W +: HUM_W];
        got_n = m_axis_tdata[TEMP_W + HUM_W +: SIW_W];
        if (expected_medians.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%08h with no reading pending",
                                    m_axis_tdata));
        end else begin
          want = expected_medians.pop_front();
          if (got_t !== want.t) begin
            report_mismatch($sformatf("temperature_median got %0d, want %0d",
                                      got_t, want.t));
          end
          if (got_h !== want.h) begin
            report_mismatch($sformatf("humidity_median got %0d, want %0d",
                                      got_h, want.h));
          end
          if (got_n !== want.n) begin
            report_mismatch($sformatf("samples_in_window got %0d, want %0d",
                                      got_n, want.n));
          end
          if (m_axis_tdata[OUT_W-1:PAD_LSB] !== '0) begin
            report_mismatch($sformatf("padding bits not zero in 0x%08h",
                                      m_axis_tdata));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_medians.push_back(slide_window(temp_t'(s_axis_tdata[TEMP_W-1:0]),
                                                hum_t'(s_axis_tdata[TEMP_W +: HUM_W])));
        accepted_readings++;
      end
    end
  end

  initial begin
    int mode;
    int t;
    int h;

    // Window growth from one reading, with range ends and full-field ends.
    queue_reading(-400, 0);
    queue_reading(800, 1000);
    queue_reading(0, 500);
    queue_reading(-1024, 1023);
    queue_reading(1023, 0);
    queue_reading(-1, 1);
    // Repeated values force ties through the rank count.
    repeat (6) queue_reading(100, 500);
    // A full window in descending order puts the median late in the ring.
    for (int i = 7; i >= 0; i--) begin
      queue_reading(i * 100, i * 100 + 200);
    end
    repeat (2) begin
      queue_reading(-400, 1000);
      queue_reading(800, 0);
    end

    // Random blocks share one kind of value so that whole windows are
    // clustered, in range, or spread over the full field width.
    for (int b = 0; b < 28; b++) begin
      mode = $urandom_range(0, 99);
      repeat (16) begin
        if (mode < 55) begin
          t = $urandom_range(0, 1200) - 400;
          h = $urandom_range(0, 1000);
        end else if (mode < 75) begin
          t = $urandom_range(0, 2047) - 1024;
          h = $urandom_range(0, 1023);
        end else begin
          t = $urandom_range(0, 2) * 5 - 5;
          h = $urandom_range(0, 2) * 5 + 500;
        end
        queue_reading(t, h);
      end
    end
    total_readings = pending_readings.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (accepted_readings != total_readings || expected_medians.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
